/* rtl/core/sle_pkg.sv */
package sle_pkg;

  localparam int unsigned LINE_DEPTH = 256;
  localparam int unsigned PTR_W      = $clog2(LINE_DEPTH);
  localparam int unsigned HEAD_DEPTH = 2;

  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef enum logic [1:0] {
    FUNC_RX   = 2'd0,
    FUNC_GET  = 2'd1,
    FUNC_READ = 2'd2,
    FUNC_NONE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_NO_CHANGE = 2'd0,
    STAT_NEW       = 2'd1,
    STAT_READY     = 2'd2,
    STAT_UNUSED    = 2'd3
  } status_e;

  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 24;

endpackage

/* rtl/core/serial_line_editor_unit.sv */
// Channel   Dir  Beat contents (lowest bit first)
// s_axis    in   tuser: func[1:0]; tdata: rx_byte[7:0], read_index[15:8]
// m_axis    out  tdata: msg_status[1:0], msg_length[9:2], read_byte[17:10], zero[23:18]
//
// One beat per cycle in unless stalled; get-message and read results appear in the next cycle.
// State is updated at the input beat's edge; the line store read is one registered RAM port.
// Receive beats and unknown func codes give no output beat.
// Reset clears write position and the ready and changed marks; store contents are undefined.
// s_axis_tready_o is low only while a result waits and m_axis_tready_i is low.
module serial_line_editor_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [sle_pkg::IN_DATA_W-1:0]      s_axis_tdata_i,  // rx_byte, read_index
  input  logic [sle_pkg::IN_USER_W-1:0]      s_axis_tuser_i,  // func
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [sle_pkg::OUT_DATA_W-1:0]     m_axis_tdata_o   // msg_status, msg_length, read_byte
);
  import sle_pkg::*;

  logic [7:0]       mem [LINE_DEPTH];
  logic [7:0]       head_q [HEAD_DEPTH];
  logic [7:0]       mem_rd_q;

  logic [PTR_W-1:0] wp_q, wp_d;
  logic             ready_q, ready_d;
  logic             changed_q, changed_d;

  logic             valid_q, valid_d;
  logic [1:0]       status_q, status_d;
  logic [7:0]       length_q, length_d;
  logic             sel_head_q, sel_head_d;
  logic [7:0]       head_byte_q, head_byte_d;

  logic             in_acc;
  logic [1:0]       func;
  logic [7:0]       rx_byte;
  logic [7:0]       read_index;
  logic             full;
  logic             st_we;
  logic [7:0]       st_wdata;
  logic             mem_we;
  logic             head_we;
  logic             esc_we;
  logic             mem_re;

  assign func       = s_axis_tuser_i;
  assign rx_byte    = s_axis_tdata_i[7:0];
  assign read_index = s_axis_tdata_i[15:8];

  assign s_axis_tready_o = !valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = wp_q >= PTR_W'(LINE_DEPTH - 1);

  always_comb begin
    wp_d        = wp_q;
    ready_d     = ready_q;
    changed_d   = changed_q;
    st_we       = 1'b0;
    st_wdata    = rx_byte;
    esc_we      = 1'b0;
    valid_d     = valid_q && !m_axis_tready_i;
    status_d    = status_q;
    length_d    = length_q;
    sel_head_d  = sel_head_q;
    head_byte_d = head_byte_q;
    mem_re      = 1'b0;
    if (in_acc) begin
      case (func)
        FUNC_RX: begin
          if (!ready_q) begin
            if (full) begin
              wp_d      = '0;
              changed_d = 1'b1;
            end else if (rx_byte == CH_ESC) begin
              esc_we    = 1'b1;
              wp_d      = PTR_W'(1);
              ready_d   = 1'b1;
              changed_d = 1'b1;
            end else if (rx_byte == CH_BS) begin
              if (wp_q == '0) begin
                changed_d = 1'b0;
              end else begin
                wp_d      = wp_q - PTR_W'(1);
                changed_d = 1'b1;
              end
            end else if (rx_byte == CH_CR || rx_byte == CH_LF) begin
              if (wp_q != '0) begin
                st_we     = 1'b1;
                st_wdata  = CH_NUL;
                ready_d   = 1'b1;
                changed_d = 1'b1;
              end
            end else begin
              st_we     = 1'b1;
              wp_d      = wp_q + PTR_W'(1);
              changed_d = 1'b1;
            end
          end
        end
        FUNC_GET: begin
          valid_d     = 1'b1;
          sel_head_d  = 1'b1;
          head_byte_d = CH_NUL;
          if (changed_q) begin
            status_d  = ready_q ? STAT_READY : STAT_NEW;
            length_d  = 8'(wp_q);
            if (ready_q) begin
              wp_d = '0;
            end
            ready_d   = 1'b0;
            changed_d = 1'b0;
          end else begin
            status_d = STAT_NO_CHANGE;
            length_d = '0;
          end
        end
        FUNC_READ: begin
          valid_d    = 1'b1;
          status_d   = STAT_NO_CHANGE;
          length_d   = '0;
          sel_head_d = read_index < 8'(HEAD_DEPTH);
          head_byte_d = head_q[read_index[0]];
          mem_re     = !sel_head_d;
        end
        default: begin
        end
      endcase
    end
  end

  assign mem_we  = st_we && (wp_q >= PTR_W'(HEAD_DEPTH));
  assign head_we = st_we && (wp_q <  PTR_W'(HEAD_DEPTH));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wp_q] <= st_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rd_q <= mem[PTR_W'(read_index)];
    end
  end

  always_ff @(posedge clk_i) begin
    if (esc_we) begin
      head_q[0] <= CH_ESC;
      head_q[1] <= CH_NUL;
    end else if (head_we) begin
      head_q[wp_q[0]] <= st_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= '0;
      ready_q   <= 1'b0;
      changed_q <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      wp_q      <= wp_d;
      ready_q   <= ready_d;
      changed_q <= changed_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    length_q    <= length_d;
    sel_head_q  <= sel_head_d;
    head_byte_q <= head_byte_d;
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = {6'b0, (sel_head_q ? head_byte_q : mem_rd_q), length_q, status_q};

  a_ready_implies_changed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ready_q |-> changed_q)
    else $error("line ready without changed mark");

  a_get_clears_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && func == FUNC_GET |=> !ready_q && !changed_q)
    else $error("get message left marks set");

  a_drop_while_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && func == FUNC_RX && ready_q |=> $stable(wp_q) && ready_q)
    else $error("byte taken while line ready");

  a_result_from_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_q) |-> $past(in_acc && (func == FUNC_GET || func == FUNC_READ)))
    else $error("result without request");

endmodule
